FILE: rtl/ppc_pkg.sv
// Shared widths, reset values and register indexes of the PID position controller.
package ppc_pkg;

   localparam int AngleWidth = 24;
   localparam int ErrorWidth = 25;
   localparam int DiffWidth = 26;
   localparam int SumWidth = 40;
   localparam int GainWidth = 16;
   localparam int DriveWidth = 16;
   localparam int FeedbackWidth = 32;
   localparam int TickWidth = 32;
   localparam int CsrAddrWidth = 3;

   localparam int ReqDataWidth = 72;
   localparam int RspDataWidth = 136;

   localparam logic signed [GainWidth-1:0] GainPropReset = 16'sd90;
   localparam logic signed [GainWidth-1:0] GainIntReset = 16'sd0;
   localparam logic signed [GainWidth-1:0] GainDerivReset = 16'sd1152;
   localparam logic signed [GainWidth-1:0] GainFfReset = 16'sd0;
   localparam logic signed [DriveWidth-1:0] DriveMinReset = 16'sh8000;
   localparam logic signed [DriveWidth-1:0] DriveMaxReset = 16'sh7fff;
   localparam logic signed [AngleWidth-1:0] PeakReset = 24'sh800000;

   localparam logic signed [SumWidth-1:0] SumMax = 40'sh7f_ffff_ffff;
   localparam logic signed [SumWidth-1:0] SumMin = 40'sh80_0000_0000;
   localparam logic signed [FeedbackWidth-1:0] FeedbackMax = 32'sh7fff_ffff;
   localparam logic signed [FeedbackWidth-1:0] FeedbackMin = 32'sh8000_0000;

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_GAIN_PROP  = 3'd0,
      CSR_GAIN_INT   = 3'd1,
      CSR_GAIN_DERIV = 3'd2,
      CSR_GAIN_FF    = 3'd3,
      CSR_DRIVE_MIN  = 3'd4,
      CSR_DRIVE_MAX  = 3'd5
   } csr_index_type;

endpackage

FILE: rtl/pid_position_controller_top.sv
// PID position controller with velocity feedforward, drive clamp, peak tracking and tick count.
//
// One control tick is taken as one item on the req_ stream and gives one item on the rsp_
// stream. The block takes a new item in every cycle unless the output stalls; three registers
// stand between the two sides: the input register, the product register (error, saturating
// integral and the four gain multiplications) and the result register (sum of products,
// scaling by 2^-8, feedback saturation and drive clamp). The integral, the previous error, the
// peak angle and the tick counter are updated as an item leaves the input register, so
// consecutive ticks see each other's state without a gap. A full pipeline stalls from the
// output side only while rsp_tready is low. Gains are to be written through the csr_ port only
// while no tick is in flight; the block itself does not enforce this.
module pid_position_controller_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // measured_angle [23:0], target_angle [47:24], target_velocity [71:48]
   input  logic [ppc_pkg::ReqDataWidth-1:0]      req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // angle_error [24:0], feedback_term [56:25], drive_out [72:57], peak_angle [96:73],
   // tick_count [128:97], zero fill [135:129]
   output logic [ppc_pkg::RspDataWidth-1:0]      rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_we,
   input  logic [ppc_pkg::CsrAddrWidth-1:0]      csr_addr,
   input  logic [ppc_pkg::GainWidth-1:0]         csr_wdata
);

   // Configuration registers
   logic signed [ppc_pkg::GainWidth-1:0]     kp_ff, ki_ff, kd_ff, kff_ff;
   logic signed [ppc_pkg::DriveWidth-1:0]    drive_min_ff, drive_max_ff;

   // Controller state
   logic signed [ppc_pkg::ErrorWidth-1:0]    prev_err_ff;
   logic signed [ppc_pkg::SumWidth-1:0]      sum_ff;
   logic signed [ppc_pkg::AngleWidth-1:0]    peak_ff;
   logic [ppc_pkg::TickWidth-1:0]            tick_ff;

   // Pipeline valid bits
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff;
   logic load0, load1, load2;

   // Input register
   logic signed [ppc_pkg::AngleWidth-1:0]    s0_meas_ff, s0_targ_ff, s0_vel_ff;

   // Product register
   logic signed [ppc_pkg::ErrorWidth-1:0]    s1_err_ff;
   logic signed [40:0]                       s1_prod_p_ff;
   logic signed [55:0]                       s1_prod_i_ff;
   logic signed [41:0]                       s1_prod_d_ff;
   logic signed [39:0]                       s1_prod_f_ff;
   logic signed [ppc_pkg::AngleWidth-1:0]    s1_peak_ff;
   logic [ppc_pkg::TickWidth-1:0]            s1_tick_ff;

   // Result register
   logic signed [ppc_pkg::ErrorWidth-1:0]    s2_err_ff;
   logic signed [ppc_pkg::FeedbackWidth-1:0] s2_fb_ff;
   logic signed [ppc_pkg::DriveWidth-1:0]    s2_drive_ff;
   logic signed [ppc_pkg::AngleWidth-1:0]    s2_peak_ff;
   logic [ppc_pkg::TickWidth-1:0]            s2_tick_ff;

   // Stage one logic
   logic signed [ppc_pkg::ErrorWidth-1:0]    err_in;
   logic signed [ppc_pkg::SumWidth:0]        sum_raw;
   logic signed [ppc_pkg::SumWidth-1:0]      sum_in;
   logic signed [ppc_pkg::DiffWidth-1:0]     diff_w;
   logic signed [ppc_pkg::AngleWidth-1:0]    peak_in;
   logic [ppc_pkg::TickWidth-1:0]            tick_in;
   logic signed [40:0]                       prod_p_in;
   logic signed [55:0]                       prod_i_in;
   logic signed [41:0]                       prod_d_in;
   logic signed [39:0]                       prod_f_in;

   // Stage two logic
   logic signed [57:0]                       pid_w;
   logic signed [58:0]                       total_w;
   logic signed [49:0]                       fb_full;
   logic signed [50:0]                       drive_full;
   logic signed [50:0]                       drive_cap;
   logic signed [ppc_pkg::FeedbackWidth-1:0] fb_in;
   logic signed [ppc_pkg::DriveWidth-1:0]    drive_in;

   assign load2 = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign load1 = s0_valid_ff && (!s1_valid_ff || load2);
   assign req_tready = !s0_valid_ff || load1;
   assign load0 = req_tvalid && req_tready;

   assign err_in = ppc_pkg::ErrorWidth'(s0_targ_ff) - ppc_pkg::ErrorWidth'(s0_meas_ff);
   assign sum_raw = (ppc_pkg::SumWidth + 1)'(sum_ff) + (ppc_pkg::SumWidth + 1)'(err_in);
   assign diff_w = ppc_pkg::DiffWidth'(err_in) - ppc_pkg::DiffWidth'(prev_err_ff);
   assign peak_in = (s0_meas_ff > peak_ff) ? s0_meas_ff : peak_ff;
   assign tick_in = tick_ff + 32'd1;

   // The integral saturates at the 40-bit limits before it is multiplied.
   always_comb begin
      case (sum_raw[ppc_pkg::SumWidth:ppc_pkg::SumWidth-1])
         2'b01: sum_in = ppc_pkg::SumMax;
         2'b10: sum_in = ppc_pkg::SumMin;
         default: sum_in = sum_raw[ppc_pkg::SumWidth-1:0];
      endcase
   end

   assign prod_p_in = 41'(kp_ff) * 41'(err_in);
   assign prod_i_in = 56'(ki_ff) * 56'(sum_in);
   assign prod_d_in = 42'(kd_ff) * 42'(diff_w);
   assign prod_f_in = 40'(kff_ff) * 40'(s0_vel_ff);

   assign pid_w = 58'(s1_prod_p_ff) + 58'(s1_prod_i_ff) + 58'(s1_prod_d_ff);
   assign total_w = 59'(pid_w) + 59'(s1_prod_f_ff);
   // Dropping the low eight bits of a two's complement value is a floor division by 256.
   assign fb_full = pid_w[57:8];
   assign drive_full = total_w[58:8];

   always_comb begin
      if ((&fb_full[49:31]) || !(|fb_full[49:31])) begin
         fb_in = fb_full[31:0];
      end else if (fb_full[49]) begin
         fb_in = ppc_pkg::FeedbackMin;
      end else begin
         fb_in = ppc_pkg::FeedbackMax;
      end
   end

   // Upper limit first, then lower, so the lower limit wins when the two cross.
   always_comb begin
      drive_cap = drive_full;
      if (drive_cap > 51'(drive_max_ff)) begin
         drive_cap = 51'(drive_max_ff);
      end
      if (drive_cap < 51'(drive_min_ff)) begin
         drive_cap = 51'(drive_min_ff);
      end
      drive_in = drive_cap[ppc_pkg::DriveWidth-1:0];
   end

   // Control state, configuration and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         kp_ff <= ppc_pkg::GainPropReset;
         ki_ff <= ppc_pkg::GainIntReset;
         kd_ff <= ppc_pkg::GainDerivReset;
         kff_ff <= ppc_pkg::GainFfReset;
         drive_min_ff <= ppc_pkg::DriveMinReset;
         drive_max_ff <= ppc_pkg::DriveMaxReset;
         prev_err_ff <= '0;
         sum_ff <= '0;
         peak_ff <= ppc_pkg::PeakReset;
         tick_ff <= '0;
      end else begin
         if (req_tready) begin
            s0_valid_ff <= req_tvalid;
         end
         if (!s1_valid_ff || load2) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (!s2_valid_ff || rsp_tready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (csr_we) begin
            case (ppc_pkg::csr_index_type'(csr_addr))
               ppc_pkg::CSR_GAIN_PROP:  kp_ff <= csr_wdata;
               ppc_pkg::CSR_GAIN_INT:   ki_ff <= csr_wdata;
               ppc_pkg::CSR_GAIN_DERIV: kd_ff <= csr_wdata;
               ppc_pkg::CSR_GAIN_FF:    kff_ff <= csr_wdata;
               ppc_pkg::CSR_DRIVE_MIN:  drive_min_ff <= csr_wdata;
               ppc_pkg::CSR_DRIVE_MAX:  drive_max_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (load1) begin
            prev_err_ff <= err_in;
            sum_ff <= sum_in;
            peak_ff <= peak_in;
            tick_ff <= tick_in;
         end
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (load0) begin
         s0_meas_ff <= req_tdata[23:0];
         s0_targ_ff <= req_tdata[47:24];
         s0_vel_ff <= req_tdata[71:48];
      end
      if (load1) begin
         s1_err_ff <= err_in;
         s1_prod_p_ff <= prod_p_in;
         s1_prod_i_ff <= prod_i_in;
         s1_prod_d_ff <= prod_d_in;
         s1_prod_f_ff <= prod_f_in;
         s1_peak_ff <= peak_in;
         s1_tick_ff <= tick_in;
      end
      if (load2) begin
         s2_err_ff <= s1_err_ff;
         s2_fb_ff <= fb_in;
         s2_drive_ff <= drive_in;
         s2_peak_ff <= s1_peak_ff;
         s2_tick_ff <= s1_tick_ff;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata = {7'd0, s2_tick_ff, s2_peak_ff, s2_drive_ff, s2_fb_ff, s2_err_ff};

   a_drive_in_limits: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && (drive_min_ff <= drive_max_ff)) |->
      (s2_drive_ff >= drive_min_ff && s2_drive_ff <= drive_max_ff))
      else $error("drive_out outside the configured limits");

   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      load1 |=> (peak_ff >= $past(peak_ff)))
      else $error("peak angle decreased");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      load1 |=> (tick_ff == $past(tick_ff) + 32'd1))
      else $error("tick counter did not advance by one");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (s0_valid_ff && !load1) |-> !req_tready)
      else $error("input taken while the input register is held");

endmodule

FILE: tb/sv/pid_position_controller_checker.sv
// Checker for the PID position controller: predicts each tick and compares every result field.
`timescale 1ns / 1ps
module pid_position_controller_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [ppc_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [ppc_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_we,
   input  logic [ppc_pkg::CsrAddrWidth-1:0] csr_addr,
   input  logic [ppc_pkg::GainWidth-1:0]    csr_wdata,
   output int                               mismatch_count,
   output int                               ticks_in_flight,
   output int                               results_checked
);

   typedef struct packed {
      logic [ppc_pkg::ErrorWidth-1:0]    angle_error;
      logic [ppc_pkg::FeedbackWidth-1:0] feedback_term;
      logic [ppc_pkg::DriveWidth-1:0]    drive_out;
      logic [ppc_pkg::AngleWidth-1:0]    peak_angle;
      logic [ppc_pkg::TickWidth-1:0]     tick_count;
   } tick_result_type;

   tick_result_type tick_results_q[$];

   logic signed [ppc_pkg::GainWidth-1:0]  kp, ki, kd, kff;
   logic signed [ppc_pkg::DriveWidth-1:0] drive_lo, drive_hi;
   logic signed [ppc_pkg::ErrorWidth-1:0] last_error;
   logic signed [ppc_pkg::AngleWidth-1:0] peak;
   logic [ppc_pkg::TickWidth-1:0]         ticks;
   longint                                integral;
   int                                    errors_seen = 0;
   int                                    compared = 0;

   initial begin
      mismatch_count = 0;
      ticks_in_flight = 0;
      results_checked = 0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors_seen++;
      $display("%0t ns: mismatch on %s after %0d results: got %h, expected %h",
               $time, what, compared, got, want);
   endtask

   task automatic predict_tick(input logic [ppc_pkg::ReqDataWidth-1:0] data);
      logic signed [ppc_pkg::AngleWidth-1:0] meas, targ, vel;
      logic signed [ppc_pkg::ErrorWidth-1:0] err;
      longint                                feedback, total, scaled, drive;
      tick_result_type                       res;
      meas = data[ppc_pkg::AngleWidth-1:0];
      targ = data[2*ppc_pkg::AngleWidth-1:ppc_pkg::AngleWidth];
      vel = data[3*ppc_pkg::AngleWidth-1:2*ppc_pkg::AngleWidth];
      err = targ - meas;

      integral = integral + longint'(err);
      if (integral > longint'(ppc_pkg::SumMax))
         integral = longint'(ppc_pkg::SumMax);
      if (integral < longint'(ppc_pkg::SumMin))
         integral = longint'(ppc_pkg::SumMin);

      feedback = longint'(kp) * longint'(err) + longint'(ki) * integral
               + longint'(kd) * (longint'(err) - longint'(last_error));
      last_error = err;
      total = feedback + longint'(kff) * longint'(vel);

      // Arithmetic shifts of a signed value round toward minus infinity.
      scaled = feedback >>> 8;
      if (scaled > longint'(ppc_pkg::FeedbackMax))
         scaled = longint'(ppc_pkg::FeedbackMax);
      if (scaled < longint'(ppc_pkg::FeedbackMin))
         scaled = longint'(ppc_pkg::FeedbackMin);

      // The upper clamp is applied first, so the lower limit wins when the two cross.
      drive = total >>> 8;
      if (drive > longint'(drive_hi))
         drive = longint'(drive_hi);
      if (drive < longint'(drive_lo))
         drive = longint'(drive_lo);

      if (meas > peak)
         peak = meas;
      ticks = ticks + 1'b1;

      res.angle_error = err;
      res.feedback_term = ppc_pkg::FeedbackWidth'(scaled);
      res.drive_out = ppc_pkg::DriveWidth'(drive);
      res.peak_angle = peak;
      res.tick_count = ticks;
      tick_results_q.push_back(res);
   endtask

   task automatic check_result(input logic [ppc_pkg::RspDataWidth-1:0] data);
      tick_result_type want, got;
      got = data[$bits(tick_result_type)-1:0];
      if (tick_results_q.size() == 0) begin
         report_mismatch("result with no tick waiting", 64'(got.tick_count), '0);
         return;
      end
      want = tick_results_q.pop_front();
      compared++;
      // The packed struct lists its fields from the top down, so it matches the bus
      // layout only after reversal; compare the bus slices directly instead.
      if (data[24:0] !== want.angle_error)
         report_mismatch("angle_error", 64'(data[24:0]), 64'(want.angle_error));
      if (data[56:25] !== want.feedback_term)
         report_mismatch("feedback_term", 64'(data[56:25]), 64'(want.feedback_term));
      if (data[72:57] !== want.drive_out)
         report_mismatch("drive_out", 64'(data[72:57]), 64'(want.drive_out));
      if (data[96:73] !== want.peak_angle)
         report_mismatch("peak_angle", 64'(data[96:73]), 64'(want.peak_angle));
      if (data[128:97] !== want.tick_count)
         report_mismatch("tick_count", 64'(data[128:97]), 64'(want.tick_count));
      if (data[ppc_pkg::RspDataWidth-1:129] !== '0)
         report_mismatch("zero fill", 64'(data[ppc_pkg::RspDataWidth-1:129]), '0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kp = ppc_pkg::GainPropReset;
         ki = ppc_pkg::GainIntReset;
         kd = ppc_pkg::GainDerivReset;
         kff = ppc_pkg::GainFfReset;
         drive_lo = ppc_pkg::DriveMinReset;
         drive_hi = ppc_pkg::DriveMaxReset;
         last_error = '0;
         integral = 0;
         peak = ppc_pkg::PeakReset;
         ticks = '0;
         tick_results_q.delete();
      end else begin
         if (csr_we) begin
            case (ppc_pkg::csr_index_type'(csr_addr))
               ppc_pkg::CSR_GAIN_PROP:  kp = csr_wdata;
               ppc_pkg::CSR_GAIN_INT:   ki = csr_wdata;
               ppc_pkg::CSR_GAIN_DERIV: kd = csr_wdata;
               ppc_pkg::CSR_GAIN_FF:    kff = csr_wdata;
               ppc_pkg::CSR_DRIVE_MIN:  drive_lo = csr_wdata;
               ppc_pkg::CSR_DRIVE_MAX:  drive_hi = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_tick(req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_result(rsp_tdata);
      end
      mismatch_count <= errors_seen;
      ticks_in_flight <= tick_results_q.size();
      results_checked <= compared;
   end

endmodule

FILE: tb/sv/pid_position_controller_top_tb.sv
// Stimulus and verdict for the PID position controller, with the checker alongside the block.
`timescale 1ns / 1ps
module pid_position_controller_top_tb;

   localparam int CycleLimit = 200_000;
   localparam logic [ppc_pkg::AngleWidth-1:0] AngleMax = 24'h7f_ffff;
   localparam logic [ppc_pkg::AngleWidth-1:0] AngleMin = 24'h80_0000;
   localparam logic [ppc_pkg::GainWidth-1:0] GainMax = 16'h7fff;
   localparam logic [ppc_pkg::GainWidth-1:0] GainMin = 16'h8000;
   localparam logic [ppc_pkg::CsrAddrWidth-1:0] CsrAddrSpareLow = 3'd6;
   localparam logic [ppc_pkg::CsrAddrWidth-1:0] CsrAddrSpareHigh = 3'd7;

   typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_EVERY_THIRD, RX_LONG_HOLD} rx_mode_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   // measured_angle [23:0], target_angle [47:24], target_velocity [71:48]
   logic [ppc_pkg::ReqDataWidth-1:0] req_tdata = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   // angle_error [24:0], feedback_term [56:25], drive_out [72:57], peak_angle [96:73],
   // tick_count [128:97], zero fill [135:129]
   logic [ppc_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic                             csr_we = 1'b0;
   logic [ppc_pkg::CsrAddrWidth-1:0] csr_addr = '0;
   logic [ppc_pkg::GainWidth-1:0]    csr_wdata = '0;

   int mismatch_count, ticks_in_flight, results_checked;
   int ticks_sent = 0;
   int settings_applied = 0;
   int burst_left = 1;
   bit gaps_on = 1'b1;
   longint cycle_count = 0;

   rx_mode_type rx_mode = RX_OPEN;
   int          rx_mode_left = 0;
   int          rx_count = 0;

   pid_position_controller_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   pid_position_controller_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tdata       (req_tdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .ticks_in_flight (ticks_in_flight),
      .results_checked (results_checked)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // The receiver moves between stall patterns of random length.
   always @(posedge clock) begin
      rx_count++;
      if (rx_mode_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 4));
         rx_mode_left = $urandom_range(50, 400);
      end else begin
         rx_mode_left--;
      end
      case (rx_mode)
         RX_OPEN:        rsp_tready <= 1'b1;
         RX_MOSTLY:      rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_SPARSE:      rsp_tready <= ($urandom_range(0, 3) == 0);
         RX_EVERY_THIRD: rsp_tready <= (rx_count % 3 == 0);
         default:        rsp_tready <= (rx_count % 16 >= 12);
      endcase
   end

   function automatic logic [ppc_pkg::AngleWidth-1:0] rand_angle(input bit narrow);
      logic [31:0] r;
      r = $urandom;
      if (narrow)
         return {{12{r[11]}}, r[11:0]};
      case ($urandom_range(0, 15))
         0: return AngleMax;
         1: return AngleMin;
         2: return '0;
         3: return '1;
         default: return r[ppc_pkg::AngleWidth-1:0];
      endcase
   endfunction

   function automatic logic [ppc_pkg::GainWidth-1:0] rand_gain(input bit narrow);
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 9))
         0: return GainMax;
         1: return GainMin;
         2: return '0;
         default: return narrow ? {{6{r[9]}}, r[9:0]} : r[ppc_pkg::GainWidth-1:0];
      endcase
   endfunction

   task automatic send_tick(input logic [ppc_pkg::AngleWidth-1:0] meas,
                            input logic [ppc_pkg::AngleWidth-1:0] targ,
                            input logic [ppc_pkg::AngleWidth-1:0] vel);
      req_tdata <= {vel, targ, meas};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      ticks_sent++;
      burst_left--;
      if (gaps_on && burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
   endtask

   // Hold the sender off until every result is back, then let the pipeline settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (ticks_in_flight != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [ppc_pkg::CsrAddrWidth-1:0] addr,
                            input logic [ppc_pkg::GainWidth-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [ppc_pkg::GainWidth-1:0] kp,
                                 input logic [ppc_pkg::GainWidth-1:0] ki,
                                 input logic [ppc_pkg::GainWidth-1:0] kd,
                                 input logic [ppc_pkg::GainWidth-1:0] kff,
                                 input logic [ppc_pkg::GainWidth-1:0] lo,
                                 input logic [ppc_pkg::GainWidth-1:0] hi,
                                 input bit with_spare);
      wait_idle();
      write_csr(ppc_pkg::CSR_GAIN_PROP, kp);
      write_csr(ppc_pkg::CSR_GAIN_INT, ki);
      write_csr(ppc_pkg::CSR_GAIN_DERIV, kd);
      write_csr(ppc_pkg::CSR_GAIN_FF, kff);
      write_csr(ppc_pkg::CSR_DRIVE_MIN, lo);
      write_csr(ppc_pkg::CSR_DRIVE_MAX, hi);
      if (with_spare) begin
         // Unused indexes must leave every register as it was.
         write_csr(CsrAddrSpareLow, '1);
         write_csr(CsrAddrSpareHigh, 16'h0001);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      settings_applied++;
   endtask

   initial begin
      logic [ppc_pkg::GainWidth-1:0] lo, hi, swap;
      int                            phase, n;
      bit                            narrow;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register values straight out of reset.
      send_tick('0, '0, '0);
      send_tick(AngleMin, AngleMax, AngleMax);
      send_tick(AngleMax, AngleMin, AngleMin);
      send_tick(AngleMin, AngleMin, '0);
      send_tick('1, 24'h55_5555, 24'haa_aaaa);

      // Extreme gains drive the feedback sum past 32 bits in both directions.
      apply_settings(GainMax, GainMax, GainMin, GainMax, GainMin, GainMax, 1'b1);
      repeat (3) send_tick(AngleMin, AngleMax, AngleMax);
      repeat (4) send_tick(AngleMax, AngleMin, AngleMin);

      // Crossed drive limits: the lower limit has to win.
      apply_settings(16'h0100, GainMin, 16'h0040, GainMin, 16'd1000, -16'sd1000, 1'b0);
      send_tick(AngleMax, AngleMin, AngleMax);
      send_tick(AngleMin, AngleMax, AngleMin);
      send_tick('0, '0, '0);
      send_tick(24'h00_0100, 24'hff_ff00, 24'h00_0001);

      for (phase = 0; phase < 8; phase++) begin
         narrow = phase[0];
         gaps_on = (phase != 2);
         lo = rand_gain(narrow);
         hi = rand_gain(narrow);
         if ($urandom_range(0, 7) != 0 && $signed(lo) > $signed(hi)) begin
            swap = lo;
            lo = hi;
            hi = swap;
         end
         if (phase == 6) begin
            lo = GainMin;
            hi = GainMax;
         end
         apply_settings(rand_gain(narrow), rand_gain(narrow), rand_gain(narrow),
                        rand_gain(narrow), lo, hi, phase == 3);
         for (n = 0; n < 130; n++) begin
            if (phase == 4 && n == 65)
               wait_idle();
            send_tick(rand_angle(narrow), rand_angle(narrow), rand_angle(narrow));
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("Sent %0d ticks under %0d register settings; %0d results compared.",
               ticks_sent, settings_applied, results_checked);
      $display("Covered field extremes, feedback overflow both ways, crossed drive limits.");
      if (mismatch_count == 0 && ticks_in_flight == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d ticks in flight.", cycle_count,
               ticks_in_flight);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: sim.f
rtl/ppc_pkg.sv
rtl/pid_position_controller_top.sv
tb/sv/pid_position_controller_checker.sv
tb/sv/pid_position_controller_top_tb.sv
